FILE: hw/rtl/spp_pkg.sv
// Shared types and constants for the sprite pixel plotter.
// Used by spp_decode, spp_stores and sprite_pixel_plotter_core; no dependencies.
package spp_pkg;

  localparam int SPP_SCREEN_WIDTH  = 128;
  localparam int SPP_SCREEN_HEIGHT = 32;
  localparam int SPP_STORE_BYTES   = 512;

  // Bits of one store byte and rows in one page.
  localparam int BYTE_W    = 8;
  localparam int PAGE_ROWS = 8;

  // Working width for signed screen coordinates.
  localparam int COORD_W = 12;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_COPY  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Decoded control for one item.
  typedef struct packed {
    op_t  op;
    logic canvas;     // 0 screen, 1 background
    logic in_range;   // target byte lies inside the store
    logic set_bit;    // plot on screen with a positive pixel
    logic on_screen;  // plotted pixel fell inside the screen
  } ctl_t;

endpackage

FILE: hw/rtl/spp_decode.sv
// Turns one input word into a store byte address, a bit mask and control flags.
// Depends on spp_pkg.
module spp_decode #(
  parameter int SCREEN_WIDTH  = spp_pkg::SPP_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = spp_pkg::SPP_SCREEN_HEIGHT,
  parameter int STORE_BYTES   = spp_pkg::SPP_STORE_BYTES,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic [1:0]    opcode,
  input  logic          canvas,
  input  logic [8:0]    origin_x,
  input  logic [8:0]    origin_y,
  input  logic [6:0]    sprite_width,
  input  logic [6:0]    sprite_height,
  input  logic          mirrored,
  input  logic [6:0]    column,
  input  logic [6:0]    row,
  input  logic [7:0]    pixel_value,
  input  logic [8:0]    byte_address,
  output spp_pkg::ctl_t ctl,
  output logic [AW-1:0] addr,
  output logic [7:0]    mask
);
  import spp_pkg::*;

  localparam int XW  = $clog2(SCREEN_WIDTH);
  localparam int YW  = $clog2(SCREEN_HEIGHT);
  localparam int PW0 = (XW + YW + 1 > 9) ? XW + YW + 1 : 9;
  localparam int PW  = (PW0 > AW) ? PW0 : AW;
  localparam logic [PW:0] LIMIT = (PW + 1)'(STORE_BYTES);

  logic [COORD_W-1:0] ox, oy, w, h, col, rw;
  logic [COORD_W-1:0] sx, sy, fy;
  logic               x_ok, y_ok, vis, pix_pos;
  logic [PW-1:0]      plot_addr, full_addr;
  op_t                op;

  always_comb begin
    op  = op_t'(opcode);
    ox  = {{(COORD_W - 9){origin_x[8]}}, origin_x};
    oy  = {{(COORD_W - 9){origin_y[8]}}, origin_y};
    w   = COORD_W'(sprite_width);
    h   = COORD_W'(sprite_height);
    col = COORD_W'(column);
    rw  = COORD_W'(row);

    sx = mirrored ? (ox + w - COORD_W'(1) - col) : (ox + col);
    sy = oy + h - rw;

    // Coordinates are non-negative when the sign bit is clear.
    x_ok = !sx[COORD_W-1] && (sx < COORD_W'(SCREEN_WIDTH));
    y_ok = !sy[COORD_W-1] && (sy < COORD_W'(SCREEN_HEIGHT));
    vis  = (op == OP_PLOT) && x_ok && y_ok;

    // Rows are stored bottom up.
    fy = COORD_W'(SCREEN_HEIGHT - 1) - sy;

    plot_addr = PW'(sx[XW-1:0])
              + (PW'(fy[YW-1:0]) >> 3) * PW'(SCREEN_WIDTH);
    full_addr = (op == OP_PLOT) ? plot_addr : PW'(byte_address);

    pix_pos = !pixel_value[7] && (pixel_value != 8'd0);

    ctl.op        = op;
    ctl.canvas    = canvas;
    ctl.in_range  = ({1'b0, full_addr} < LIMIT);
    ctl.set_bit   = vis && pix_pos;
    ctl.on_screen = vis;

    addr = full_addr[AW-1:0];
    mask = BYTE_W'(1) << fy[2:0];
  end

endmodule

FILE: hw/rtl/spp_stores.sv
// Screen and background byte stores with the clearing sweep after reset,
// registered reads and forwarding of the write that lands on the read edge.
// Depends on spp_pkg.
module spp_stores #(
  parameter int STORE_BYTES = spp_pkg::SPP_STORE_BYTES,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  spp_pkg::ctl_t wr_ctl,
  input  logic [7:0]    wr_mask,
  output logic [7:0]    scr_data,
  output logic [7:0]    bkg_data,
  output logic          clearing
);
  import spp_pkg::*;

  logic [BYTE_W-1:0] scr_mem [STORE_BYTES];
  logic [BYTE_W-1:0] bkg_mem [STORE_BYTES];

  logic [BYTE_W-1:0] scr_q, bkg_q;
  logic [AW-1:0]     raddr;
  logic              fwd;
  logic              lw_scr;
  logic [AW-1:0]     lw_addr;
  logic [BYTE_W-1:0] lw_data;
  logic [AW-1:0]     clr_cnt;

  logic              hit;
  logic              wr_scr, wr_bkg;
  logic [BYTE_W-1:0] wr_data;

  // The read issued together with the previous item's write misses that
  // write, so the held byte is patched from the last-write record.
  always_comb begin
    hit      = fwd && (lw_addr == raddr);
    scr_data = (hit && lw_scr)  ? lw_data : scr_q;
    bkg_data = (hit && !lw_scr) ? lw_data : bkg_q;

    wr_scr  = 1'b0;
    wr_bkg  = 1'b0;
    wr_data = '0;
    if (wr_en && wr_ctl.in_range) begin
      case (wr_ctl.op)
        OP_PLOT: begin
          if (wr_ctl.set_bit) begin
            wr_scr  = !wr_ctl.canvas;
            wr_bkg  = wr_ctl.canvas;
            wr_data = (wr_ctl.canvas ? bkg_data : scr_data) | wr_mask;
          end
        end
        OP_CLEAR: begin
          wr_bkg  = 1'b1;
          wr_data = '0;
        end
        OP_COPY: begin
          wr_scr  = 1'b1;
          wr_data = bkg_data;
        end
        default: begin
          wr_scr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      scr_mem[clr_cnt] <= '0;
      bkg_mem[clr_cnt] <= '0;
    end else begin
      if (wr_scr) scr_mem[raddr] <= wr_data;
      if (wr_bkg) bkg_mem[raddr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      scr_q <= scr_mem[rd_addr];
      bkg_q <= bkg_mem[rd_addr];
      raddr <= rd_addr;
    end
    if (wr_scr || wr_bkg) begin
      lw_scr  <= wr_scr;
      lw_addr <= raddr;
      lw_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd      <= 1'b0;
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      if (rd_en) fwd <= wr_scr || wr_bkg;
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(STORE_BYTES - 1)) clearing <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/sprite_pixel_plotter_core.sv
// Sprite pixel plotter: two page-organized one-bit canvases behind a stream port.
// Depends on spp_pkg, spp_decode and spp_stores.
//
// Each accepted word is one store operation (plot a sprite pixel, clear a
// background byte, copy a background byte to the screen, or read a byte) and
// yields one result word. One word is taken every clock cycle while the output
// is not held back by m_tready and the clearing sweep is done. The store read
// is registered on the accepting edge, and the read-modify-write and the output
// register complete when the item advances to the output. After reset the block
// sweeps both stores to zero, one byte a cycle, and holds s_tready low until the
// sweep is done.
module sprite_pixel_plotter_core #(
  parameter int SCREEN_WIDTH  = spp_pkg::SPP_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = spp_pkg::SPP_SCREEN_HEIGHT,
  parameter int STORE_BYTES   = spp_pkg::SPP_STORE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // origin_x[8:0], origin_y[17:9], sprite_width[24:18], sprite_height[31:25],
  // mirrored[32], column[39:33], row[46:40], pixel_value[54:47],
  // byte_address[63:55]
  input  logic [63:0] s_tdata,
  // opcode[1:0], canvas[2]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], on_screen[8], zero fill[15:9]
  output logic [15:0] m_tdata
);
  import spp_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  ctl_t              dec_ctl, st_ctl;
  logic [AW-1:0]     dec_addr;
  logic [BYTE_W-1:0] dec_mask, st_mask;
  logic              st_valid;
  logic              accept, advance, clearing;
  logic [BYTE_W-1:0] scr_data, bkg_data, rd_byte;
  logic [BYTE_W-1:0] read_data;
  logic              on_screen;

  spp_decode #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .STORE_BYTES  (STORE_BYTES)
  ) u_decode (
    .opcode       (s_tuser[1:0]),
    .canvas       (s_tuser[2]),
    .origin_x     (s_tdata[8:0]),
    .origin_y     (s_tdata[17:9]),
    .sprite_width (s_tdata[24:18]),
    .sprite_height(s_tdata[31:25]),
    .mirrored     (s_tdata[32]),
    .column       (s_tdata[39:33]),
    .row          (s_tdata[46:40]),
    .pixel_value  (s_tdata[54:47]),
    .byte_address (s_tdata[63:55]),
    .ctl          (dec_ctl),
    .addr         (dec_addr),
    .mask         (dec_mask)
  );

  spp_stores #(
    .STORE_BYTES(STORE_BYTES)
  ) u_stores (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (dec_addr),
    .wr_en   (advance),
    .wr_ctl  (st_ctl),
    .wr_mask (st_mask),
    .scr_data(scr_data),
    .bkg_data(bkg_data),
    .clearing(clearing)
  );

  always_comb begin
    advance  = st_valid && (!m_tvalid || m_tready);
    s_tready = !clearing && (!st_valid || advance);
    accept   = s_tvalid && s_tready;
    rd_byte  = st_ctl.canvas ? bkg_data : scr_data;
    m_tdata  = {7'd0, on_screen, read_data};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_ctl  <= dec_ctl;
      st_mask <= dec_mask;
    end
    if (advance) begin
      read_data <= (st_ctl.op == OP_READ && st_ctl.in_range) ? rd_byte : '0;
      on_screen <= st_ctl.on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept)       st_valid <= 1'b1;
      else if (advance) st_valid <= 1'b0;
      if (advance)       m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule
